>>> sv/dsdp_pkg.sv
// dsdp_pkg: shared constants, codes and control types for the dual stack unit
// no dependencies; imported by every module of the block
package dsdp_pkg;

	localparam int DEPTH     = 16;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DATA_W    = 32;
	localparam int REQ_W     = 3;
	localparam int STAT_W    = 3;
	localparam int OUT_CNT_W = 5;
	localparam int UPC_W     = 4;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_A = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_B = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_A  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_B  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PURGE  = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK            = 3'd0;
	localparam logic [STAT_W-1:0] ST_POP_EMPTY     = 3'd1;
	localparam logic [STAT_W-1:0] ST_PUSH_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_PURGE_A_EMPTY = 3'd3;
	localparam logic [STAT_W-1:0] ST_PURGE_B_EMPTY = 3'd4;

	// microprogram step addresses
	localparam logic [UPC_W-1:0] STEP_WAIT     = 4'd0;
	localparam logic [UPC_W-1:0] STEP_PUSH_A   = 4'd1;
	localparam logic [UPC_W-1:0] STEP_PUSH_B   = 4'd2;
	localparam logic [UPC_W-1:0] STEP_POP_A    = 4'd3;
	localparam logic [UPC_W-1:0] STEP_POP_A_RD = 4'd4;
	localparam logic [UPC_W-1:0] STEP_POP_B    = 4'd5;
	localparam logic [UPC_W-1:0] STEP_POP_B_RD = 4'd6;
	localparam logic [UPC_W-1:0] STEP_PURGE    = 4'd7;
	localparam logic [UPC_W-1:0] STEP_RD_A     = 4'd8;
	localparam logic [UPC_W-1:0] STEP_LATCH    = 4'd9;
	localparam logic [UPC_W-1:0] STEP_CMP      = 4'd10;
	localparam logic [UPC_W-1:0] STEP_KEEP     = 4'd11;
	localparam logic [UPC_W-1:0] STEP_ADV      = 4'd12;
	localparam logic [UPC_W-1:0] STEP_FIN      = 4'd13;
	localparam logic [UPC_W-1:0] STEP_NOP      = 4'd14;

	// datapath action of one step
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_PUSH_A,
		ACT_PUSH_B,
		ACT_POP_A,
		ACT_POP_A_RD,
		ACT_POP_B,
		ACT_POP_B_RD,
		ACT_PURGE_INIT,
		ACT_READ_A,
		ACT_LATCH,
		ACT_CMP,
		ACT_KEEP,
		ACT_ADV,
		ACT_PURGE_DONE,
		ACT_NOP_RESP
	} act_t;

	// sequencing of one step
	typedef enum logic [2:0] {
		C_NEXT,
		C_GOTO,
		C_DISPATCH,
		C_IF,
		C_SCAN
	} cond_t;

	// flag tested by a conditional jump
	typedef enum logic [1:0] {
		F_A_EMPTY,
		F_B_EMPTY,
		F_NO_PURGE,
		F_A_MORE
	} flag_sel_t;

	typedef struct packed {
		act_t             act;
		cond_t            cond;
		flag_sel_t        fsel;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic a_empty;
		logic b_empty;
		logic a_more;
		logic match;
		logic b_last;
	} flags_t;

endpackage

>>> sv/dual_stack_with_difference_purge_unit.sv
// push, empty pop, refused purge, unused code: the entry step after accept gives the reply
// pop: a further step gives the registered store read; purge: for each entry of a it reads,
// latches, scans b, keeps it if unmatched, advances; microprogram walks both stores
// results show for one cycle on done, in the cycle busy drops; the receiver cannot stall
// reset clears both fill counts and the step counter; store contents stay undefined
module dual_stack_with_difference_purge_unit import dsdp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [REQ_W-1:0]         req_type,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic signed [DATA_W-1:0] data,
	output logic [STAT_W-1:0]        status,
	output logic [OUT_CNT_W-1:0]     count_a,
	output logic [OUT_CNT_W-1:0]     count_b
);

	// control word from the rom and flags back from the datapath
	ctrl_t  ctrl;
	flags_t flags;
	logic   accept;

	// a request transfer happens only while the sequencer waits at its first step
	assign accept = start & ~busy;

	// step counter, rom and jump logic
	dsdp_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.flags    (flags),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	// stores, counts, scan indices and result registers
	dsdp_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.value   (value),
		.ctrl    (ctrl),
		.flags   (flags),
		.done    (done),
		.data    (data),
		.status  (status),
		.count_a (count_a),
		.count_b (count_b)
	);

	// a result only appears once the program is back at its wait step
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	// an accepted request always leaves the wait step
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request accepted but sequencer stayed idle");

	// fill counts never exceed the store depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_a <= OUT_CNT_W'(DEPTH)) && (count_b <= OUT_CNT_W'(DEPTH)))
		else $error("fill count beyond depth");

	// an empty pop returns all ones
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_POP_EMPTY) |-> (data == '1))
		else $error("empty pop with wrong data");

	// a refused purge leaves stack a unchanged
	a_purge_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_PURGE_A_EMPTY || status == ST_PURGE_B_EMPTY))
			|-> $stable(count_a))
		else $error("refused purge changed stack a");

endmodule

>>> sv/dsdp_sequencer.sv
// dsdp_sequencer: step counter, microprogram rom and next-step logic
// depends on dsdp_pkg for control word and flag types
module dsdp_sequencer import dsdp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [REQ_W-1:0] req_type,
	input  flags_t           flags,
	output ctrl_t            ctrl,
	output logic             busy
);

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;
	logic [UPC_W-1:0] upc_inc;
	logic             flag;

	function automatic ctrl_t cw(input act_t a, input cond_t c, input flag_sel_t f,
			input logic [UPC_W-1:0] t);
		ctrl_t w;
		w.act    = a;
		w.cond   = c;
		w.fsel   = f;
		w.target = t;
		return w;
	endfunction

	// the microprogram
	function automatic ctrl_t rom(input logic [UPC_W-1:0] s);
		ctrl_t w;
		case (s)
			STEP_WAIT:     w = cw(ACT_NONE,       C_DISPATCH, F_A_EMPTY,  STEP_WAIT);
			STEP_PUSH_A:   w = cw(ACT_PUSH_A,     C_GOTO,     F_A_EMPTY,  STEP_WAIT);
			STEP_PUSH_B:   w = cw(ACT_PUSH_B,     C_GOTO,     F_A_EMPTY,  STEP_WAIT);
			STEP_POP_A:    w = cw(ACT_POP_A,      C_IF,       F_A_EMPTY,  STEP_WAIT);
			STEP_POP_A_RD: w = cw(ACT_POP_A_RD,   C_GOTO,     F_A_EMPTY,  STEP_WAIT);
			STEP_POP_B:    w = cw(ACT_POP_B,      C_IF,       F_B_EMPTY,  STEP_WAIT);
			STEP_POP_B_RD: w = cw(ACT_POP_B_RD,   C_GOTO,     F_A_EMPTY,  STEP_WAIT);
			STEP_PURGE:    w = cw(ACT_PURGE_INIT, C_IF,       F_NO_PURGE, STEP_WAIT);
			STEP_RD_A:     w = cw(ACT_READ_A,     C_NEXT,     F_A_EMPTY,  STEP_WAIT);
			STEP_LATCH:    w = cw(ACT_LATCH,      C_NEXT,     F_A_EMPTY,  STEP_WAIT);
			STEP_CMP:      w = cw(ACT_CMP,        C_SCAN,     F_A_EMPTY,  STEP_ADV);
			STEP_KEEP:     w = cw(ACT_KEEP,       C_NEXT,     F_A_EMPTY,  STEP_WAIT);
			STEP_ADV:      w = cw(ACT_ADV,        C_IF,       F_A_MORE,   STEP_RD_A);
			STEP_FIN:      w = cw(ACT_PURGE_DONE, C_GOTO,     F_A_EMPTY,  STEP_WAIT);
			STEP_NOP:      w = cw(ACT_NOP_RESP,   C_GOTO,     F_A_EMPTY,  STEP_WAIT);
			default:       w = cw(ACT_NONE,       C_GOTO,     F_A_EMPTY,  STEP_WAIT);
		endcase
		return w;
	endfunction

	// entry step of each request
	function automatic logic [UPC_W-1:0] dispatch(input logic [REQ_W-1:0] r);
		logic [UPC_W-1:0] s;
		case (r)
			REQ_PUSH_A: s = STEP_PUSH_A;
			REQ_PUSH_B: s = STEP_PUSH_B;
			REQ_POP_A:  s = STEP_POP_A;
			REQ_POP_B:  s = STEP_POP_B;
			REQ_PURGE:  s = STEP_PURGE;
			default:    s = STEP_NOP;
		endcase
		return s;
	endfunction

	assign ctrl    = rom(upc_q);
	assign busy    = (upc_q != STEP_WAIT);
	assign upc_inc = upc_q + UPC_W'(1);

	always_comb begin
		case (ctrl.fsel)
			F_A_EMPTY:  flag = flags.a_empty;
			F_B_EMPTY:  flag = flags.b_empty;
			F_NO_PURGE: flag = flags.a_empty | flags.b_empty;
			F_A_MORE:   flag = flags.a_more;
			default:    flag = 1'b0;
		endcase
	end

	always_comb begin
		case (ctrl.cond)
			C_NEXT:     upc_nxt = upc_inc;
			C_GOTO:     upc_nxt = ctrl.target;
			C_DISPATCH: upc_nxt = start ? dispatch(req_type) : upc_q;
			C_IF:       upc_nxt = flag ? ctrl.target : upc_inc;
			C_SCAN: begin
				if (flags.match) begin
					upc_nxt = ctrl.target;
				end else if (flags.b_last) begin
					upc_nxt = upc_inc;
				end else begin
					upc_nxt = upc_q;
				end
			end
			default:    upc_nxt = STEP_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_WAIT;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

>>> sv/dsdp_datapath.sv
// dsdp_datapath: the two stores, fill counts, scan indices and result registers
// depends on dsdp_pkg; driven by the control word of dsdp_sequencer
module dsdp_datapath import dsdp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic signed [DATA_W-1:0] value,
	input  ctrl_t                    ctrl,
	output flags_t                   flags,
	output logic                     done,
	output logic signed [DATA_W-1:0] data,
	output logic [STAT_W-1:0]        status,
	output logic [OUT_CNT_W-1:0]     count_a,
	output logic [OUT_CNT_W-1:0]     count_b
);

	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];
	logic [DATA_W-1:0] rdata_a_q, rdata_b_q;

	logic [CNT_W-1:0]  fill_a_q, fill_b_q, wr_q;
	logic [IDX_W-1:0]  rd_q, k_q;
	logic [DATA_W-1:0] value_q, val_q, data_q;
	logic [STAT_W-1:0] status_q;
	logic              done_q;

	logic [CNT_W-1:0]  fill_a_dec, fill_b_dec;
	logic              full_a, full_b;
	logic              we_a, we_b;
	logic [IDX_W-1:0]  waddr_a, waddr_b, raddr_a, raddr_b;
	logic [DATA_W-1:0] wdata_a;
	logic              resp;
	logic [DATA_W-1:0] resp_data;
	logic [STAT_W-1:0] resp_status;

	assign fill_a_dec = fill_a_q - CNT_W'(1);
	assign fill_b_dec = fill_b_q - CNT_W'(1);
	assign full_a     = (fill_a_q >= CNT_W'(DEPTH));
	assign full_b     = (fill_b_q >= CNT_W'(DEPTH));

	assign flags.a_empty = (fill_a_q == '0);
	assign flags.b_empty = (fill_b_q == '0);
	assign flags.a_more  = ((CNT_W'(rd_q) + CNT_W'(1)) < fill_a_q);
	assign flags.match   = (rdata_b_q == val_q);
	assign flags.b_last  = ((CNT_W'(k_q) + CNT_W'(1)) == fill_b_q);

	// store ports
	always_comb begin
		we_a    = 1'b0;
		we_b    = 1'b0;
		waddr_a = fill_a_q[IDX_W-1:0];
		waddr_b = fill_b_q[IDX_W-1:0];
		wdata_a = value_q;
		raddr_a = rd_q;
		raddr_b = k_q;
		case (ctrl.act)
			ACT_PUSH_A: we_a = !full_a;
			ACT_PUSH_B: we_b = !full_b;
			ACT_POP_A:  raddr_a = fill_a_dec[IDX_W-1:0];
			ACT_POP_B:  raddr_b = fill_b_dec[IDX_W-1:0];
			ACT_LATCH:  raddr_b = '0;
			ACT_CMP:    raddr_b = k_q + IDX_W'(1);
			ACT_KEEP: begin
				we_a    = 1'b1;
				waddr_a = wr_q[IDX_W-1:0];
				wdata_a = val_q;
			end
			default: ;
		endcase
	end

	// result of the step, if it ends a request
	always_comb begin
		resp        = 1'b0;
		resp_data   = '0;
		resp_status = ST_OK;
		case (ctrl.act)
			ACT_PUSH_A: begin
				resp        = 1'b1;
				resp_status = full_a ? ST_PUSH_FULL : ST_OK;
			end
			ACT_PUSH_B: begin
				resp        = 1'b1;
				resp_status = full_b ? ST_PUSH_FULL : ST_OK;
			end
			ACT_POP_A: begin
				resp        = flags.a_empty;
				resp_data   = '1;
				resp_status = ST_POP_EMPTY;
			end
			ACT_POP_B: begin
				resp        = flags.b_empty;
				resp_data   = '1;
				resp_status = ST_POP_EMPTY;
			end
			ACT_POP_A_RD: begin
				resp      = 1'b1;
				resp_data = rdata_a_q;
			end
			ACT_POP_B_RD: begin
				resp      = 1'b1;
				resp_data = rdata_b_q;
			end
			ACT_PURGE_INIT: begin
				resp        = flags.a_empty | flags.b_empty;
				resp_status = flags.a_empty ? ST_PURGE_A_EMPTY : ST_PURGE_B_EMPTY;
			end
			ACT_PURGE_DONE: resp = 1'b1;
			ACT_NOP_RESP:   resp = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr_a] <= wdata_a;
		end
		if (we_b) begin
			mem_b[waddr_b] <= value_q;
		end
		rdata_a_q <= mem_a[raddr_a];
		rdata_b_q <= mem_b[raddr_b];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
		end
		if (ctrl.act == ACT_LATCH) begin
			val_q <= rdata_a_q;
		end
		if (resp) begin
			data_q   <= resp_data;
			status_q <= resp_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_a_q <= '0;
			fill_b_q <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			k_q      <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= resp;
			case (ctrl.act)
				ACT_PUSH_A: if (!full_a) fill_a_q <= fill_a_q + CNT_W'(1);
				ACT_PUSH_B: if (!full_b) fill_b_q <= fill_b_q + CNT_W'(1);
				ACT_POP_A:  if (!flags.a_empty) fill_a_q <= fill_a_dec;
				ACT_POP_B:  if (!flags.b_empty) fill_b_q <= fill_b_dec;
				ACT_PURGE_INIT: begin
					rd_q <= '0;
					wr_q <= '0;
				end
				ACT_LATCH:      k_q <= '0;
				ACT_CMP:        k_q <= k_q + IDX_W'(1);
				ACT_KEEP:       wr_q <= wr_q + CNT_W'(1);
				ACT_ADV:        rd_q <= rd_q + IDX_W'(1);
				ACT_PURGE_DONE: fill_a_q <= wr_q;
				default: ;
			endcase
		end
	end

	assign done    = done_q;
	assign data    = data_q;
	assign status  = status_q;
	assign count_a = OUT_CNT_W'(fill_a_q);
	assign count_b = OUT_CNT_W'(fill_b_q);

endmodule

>>> tb/sv/dual_stack_with_difference_purge_unit_tb.sv
// self-checking bench for dual_stack_with_difference_purge_unit: a scoreboard class tracks both
// stacks and queues the expected reply of every accepted request; tasks drive the command side
// depends on dsdp_pkg and the unit itself
module dual_stack_with_difference_purge_unit_tb;
	import dsdp_pkg::*;

	// codes the unit treats as a no-op with a plain ok reply
	localparam logic [REQ_W-1:0] REQ_SPARE_LO  = REQ_PURGE + 3'd1;
	localparam logic [REQ_W-1:0] REQ_SPARE_MID = REQ_PURGE + 3'd2;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI  = '1;

	localparam int RANDOM_ITEMS  = 1525;
	localparam int QUIET_TAIL    = 200;     // no idling over the last stretch
	localparam int DRAIN_EVERY   = 250;     // sender waits for every reply this often
	localparam int SETTLE_CYCLES = 2 + DEPTH * (DEPTH + 4) + 20;
	localparam int CYCLE_LIMIT   = 3_000_000;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [STAT_W-1:0]        status;
		logic [OUT_CNT_W-1:0]     count_a;
		logic [OUT_CNT_W-1:0]     count_b;
	} reply_t;

	// mirror of the two stacks plus the queue of replies still owed by the unit
	class stack_pair_model;
		logic signed [DATA_W-1:0] stack_a [DEPTH];
		logic signed [DATA_W-1:0] stack_b [DEPTH];
		int     depth_a;
		int     depth_b;
		reply_t awaited [$];
		int     errors;
		int     requests;
		int     replies;
		int     purged_entries;
		int     status_seen [8];

		function void note_request(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] val);
			reply_t r;
			int     kept;
			bit     hit;
			r.data   = '0;
			r.status = ST_OK;
			case (req)
				REQ_PUSH_A: begin
					if (depth_a >= DEPTH) r.status = ST_PUSH_FULL;
					else begin
						stack_a[depth_a] = val;
						depth_a++;
					end
				end
				REQ_PUSH_B: begin
					if (depth_b >= DEPTH) r.status = ST_PUSH_FULL;
					else begin
						stack_b[depth_b] = val;
						depth_b++;
					end
				end
				REQ_POP_A: begin
					if (depth_a == 0) begin
						r.data   = -1;
						r.status = ST_POP_EMPTY;
					end else begin
						depth_a--;
						r.data = stack_a[depth_a];
					end
				end
				REQ_POP_B: begin
					if (depth_b == 0) begin
						r.data   = -1;
						r.status = ST_POP_EMPTY;
					end else begin
						depth_b--;
						r.data = stack_b[depth_b];
					end
				end
				REQ_PURGE: begin
					// a empty is checked first, so it wins when both are empty
					if (depth_a == 0) r.status = ST_PURGE_A_EMPTY;
					else if (depth_b == 0) r.status = ST_PURGE_B_EMPTY;
					else begin
						kept = 0;
						for (int i = 0; i < depth_a; i++) begin
							hit = 1'b0;
							for (int j = 0; j < depth_b; j++)
								if (stack_b[j] == stack_a[i]) hit = 1'b1;
							if (!hit) begin
								stack_a[kept] = stack_a[i];
								kept++;
							end
						end
						purged_entries += depth_a - kept;
						depth_a = kept;
					end
				end
				default: ;
			endcase
			r.count_a = OUT_CNT_W'(depth_a);
			r.count_b = OUT_CNT_W'(depth_b);
			status_seen[r.status]++;
			requests++;
			awaited.push_back(r);
		endfunction

		function void check_reply(logic signed [DATA_W-1:0] got_data,
				logic [STAT_W-1:0] got_status, logic [OUT_CNT_W-1:0] got_a,
				logic [OUT_CNT_W-1:0] got_b);
			reply_t r;
			replies++;
			if (awaited.size() == 0) begin
				$error("reply with none outstanding: data %0d status %0d", got_data, got_status);
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (got_data !== r.data) begin
				$error("data: expected %0d, got %0d", r.data, got_data);
				errors++;
			end
			if (got_status !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, got_status);
				errors++;
			end
			if (got_a !== r.count_a) begin
				$error("count_a: expected %0d, got %0d", r.count_a, got_a);
				errors++;
			end
			if (got_b !== r.count_b) begin
				$error("count_b: expected %0d, got %0d", r.count_b, got_b);
				errors++;
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [REQ_W-1:0]         req_type;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic signed [DATA_W-1:0] data;
	logic [STAT_W-1:0]        status;
	logic [OUT_CNT_W-1:0]     count_a;
	logic [OUT_CNT_W-1:0]     count_b;

	stack_pair_model expected_stacks;
	int              cycles;

	dual_stack_with_difference_purge_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.value    (value),
		.done     (done),
		.data     (data),
		.status   (status),
		.count_a  (count_a),
		.count_b  (count_b)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a stuck handshake or a lost reply ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("dual_stack_with_difference_purge_unit_tb: done, errors");
			$finish;
		end
	end

	// monitor: replies are checked before the transfer on the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				expected_stacks.check_reply(data, status, count_a, count_b);
			if (start && !busy)
				expected_stacks.note_request(req_type, value);
		end
	end

	// present one request and hold it until the unit takes it; returns on a falling edge
	task automatic issue(input logic [REQ_W-1:0] req, input logic signed [DATA_W-1:0] val);
		start    <= 1'b1;
		req_type <= req;
		value    <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// sender holds off until the unit owes nothing
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (expected_stacks.outstanding() != 0) @(negedge clk);
	endtask

	// request mix shifts with the phase: filling, balanced or emptying
	function automatic logic [REQ_W-1:0] pick_request(input int mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			0: begin
				if (r < 40) return REQ_PUSH_A;
				if (r < 75) return REQ_PUSH_B;
				if (r < 85) return REQ_POP_A;
				if (r < 90) return REQ_POP_B;
				if (r < 97) return REQ_PURGE;
			end
			1: begin
				if (r < 23) return REQ_PUSH_A;
				if (r < 45) return REQ_PUSH_B;
				if (r < 64) return REQ_POP_A;
				if (r < 82) return REQ_POP_B;
				if (r < 97) return REQ_PURGE;
			end
			default: begin
				if (r < 10) return REQ_PUSH_A;
				if (r < 20) return REQ_PUSH_B;
				if (r < 55) return REQ_POP_A;
				if (r < 85) return REQ_POP_B;
				if (r < 97) return REQ_PURGE;
			end
		endcase
		return REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
	endfunction

	// mostly a small set of values so that purges find matches in b
	function automatic logic signed [DATA_W-1:0] draw_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			case ($urandom_range(0, 5))
				0:       return 32'sh8000_0000;
				1:       return 32'sh7FFF_FFFF;
				2:       return -1;
				3:       return 0;
				4:       return 32'sh5555_5555;
				default: return 32'shAAAA_AAAA;
			endcase
		end
		if (r < 75) return DATA_W'($urandom_range(0, 15));
		return $urandom();
	endfunction

	initial begin
		int mode;
		int idle_pct;
		expected_stacks = new;
		cycles   = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		req_type = REQ_PUSH_A;
		value    = '0;
		mode     = 1;
		idle_pct = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty pops, both purge refusals, extremes, a real purge, spare codes
		issue(REQ_POP_A, 32'sh1234_5678);
		issue(REQ_POP_B, 0);
		issue(REQ_PURGE, 0);
		issue(REQ_PUSH_A, 32'sh8000_0000);
		issue(REQ_PURGE, 0);
		issue(REQ_PUSH_A, 32'sh7FFF_FFFF);
		issue(REQ_PUSH_A, -1);
		issue(REQ_PUSH_A, 0);
		issue(REQ_PUSH_B, -1);
		issue(REQ_PUSH_B, 32'sh8000_0000);
		issue(REQ_PUSH_B, 32'sh5555_5555);
		idle(3);
		issue(REQ_PURGE, -1);
		issue(REQ_POP_A, 0);
		issue(REQ_POP_B, 0);
		issue(REQ_POP_B, 0);
		issue(REQ_SPARE_LO, 32'shAAAA_AAAA);
		issue(REQ_SPARE_MID, 0);
		issue(REQ_SPARE_HI, -1);
		issue(REQ_POP_A, 0);
		issue(REQ_POP_A, 0);
		issue(REQ_PURGE, 0);
		issue(REQ_POP_B, 0);
		issue(REQ_POP_B, 0);
		drain();

		// random: phases of filling and emptying, idle bursts switched on and off per phase
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				mode     = $urandom_range(0, 2);
				idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
			end
			if (n < RANDOM_ITEMS - QUIET_TAIL && n % DRAIN_EVERY == DRAIN_EVERY - 1)
				drain();
			if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
				idle($urandom_range(1, 15));
			issue(pick_request(mode), draw_value());
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run covered %0d requests, %0d replies: %0d empty pops, %0d full pushes",
			expected_stacks.requests, expected_stacks.replies,
			expected_stacks.status_seen[ST_POP_EMPTY], expected_stacks.status_seen[ST_PUSH_FULL]);
		$display("purges refused on empty a/b: %0d/%0d, entries removed by purges: %0d",
			expected_stacks.status_seen[ST_PURGE_A_EMPTY],
			expected_stacks.status_seen[ST_PURGE_B_EMPTY], expected_stacks.purged_entries);
		if (expected_stacks.errors == 0)
			$display("dual_stack_with_difference_purge_unit_tb: done, clean");
		else
			$display("dual_stack_with_difference_purge_unit_tb: done, errors");
		$finish;
	end

endmodule

>>> files.f
sv/dsdp_pkg.sv
sv/dsdp_sequencer.sv
sv/dsdp_datapath.sv
sv/dual_stack_with_difference_purge_unit.sv
tb/sv/dual_stack_with_difference_purge_unit_tb.sv
